/* sv/dedup_trapezoid_integrator_macros.svh */
// ---------------------------------------------------------------------------
// dedup_trapezoid_integrator_macros.svh
// Assertion macros used by the integrator top level.
// ---------------------------------------------------------------------------
`ifndef DEDUP_TRAPEZOID_INTEGRATOR_MACROS_SVH
`define DEDUP_TRAPEZOID_INTEGRATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DTI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/dti_pkg.sv */
// ---------------------------------------------------------------------------
// dti_pkg
// Widths and the stage record shared by the integrator modules.
// ---------------------------------------------------------------------------
package dti_pkg;

   localparam int unsigned CoordWidth = 32;   // Q16.16 x and y
   localparam int unsigned StepWidth  = 31;   // min_step register
   localparam int unsigned PathWidth  = 63;   // unsigned Q31.32
   localparam int unsigned EnergyWidth = 64;  // signed Q32.32
   localparam int unsigned PathStepWidth = CoordWidth + 16;  // |dx| << 16

   // Record handed from the filter stage to the accumulator stage.
   typedef struct packed {
      logic                            start;      // clear the sums
      logic signed [CoordWidth-1:0]    x;
      logic signed [CoordWidth-1:0]    y;
      logic        [PathStepWidth-1:0] path_step;  // Q16.32 path increment
      logic signed [EnergyWidth-1:0]   term;       // Q32.32 energy increment
   } dti_step_type;

endpackage

/* sv/dti_filter.sv */
// ---------------------------------------------------------------------------
// dti_filter
// Keep/drop decision against the previous raw x, and the path and energy
// increments of a kept point against the last kept point.
// ---------------------------------------------------------------------------
module dti_filter (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic signed [dti_pkg::CoordWidth-1:0]    x_value,
   input  logic signed [dti_pkg::CoordWidth-1:0]    y_value,
   input  logic                                     curve_start,
   input  logic        [dti_pkg::StepWidth-1:0]     min_step,
   output logic                                     keep,
   output dti_pkg::dti_step_type                    step
);
   import dti_pkg::*;

   logic signed [CoordWidth-1:0] prev_raw_x_ff, prev_raw_x_in;
   logic signed [CoordWidth-1:0] last_kept_x_ff, last_kept_x_in;
   logic signed [CoordWidth-1:0] last_kept_y_ff, last_kept_y_in;
   logic                         have_point_ff, have_point_in;

   logic                         start_eff;
   logic signed [CoordWidth:0]   raw_diff;
   logic        [CoordWidth:0]   raw_mag;
   logic signed [CoordWidth:0]   dx;
   logic signed [CoordWidth:0]   ys;
   logic        [CoordWidth:0]   dx_mag;
   logic        [CoordWidth:0]   ys_mag;
   logic        [2*CoordWidth:0] product;
   logic        [EnergyWidth-2:0] half_product;

   always_comb begin
      start_eff = curve_start || !have_point_ff;

      raw_diff = {x_value[CoordWidth-1], x_value} - {prev_raw_x_ff[CoordWidth-1], prev_raw_x_ff};
      raw_mag  = raw_diff[CoordWidth] ? (~raw_diff + 1'b1) : raw_diff;
      keep     = start_eff || (raw_mag >= {2'b00, min_step});

      dx     = {x_value[CoordWidth-1], x_value} - {last_kept_x_ff[CoordWidth-1], last_kept_x_ff};
      ys     = {y_value[CoordWidth-1], y_value} + {last_kept_y_ff[CoordWidth-1], last_kept_y_ff};
      dx_mag = dx[CoordWidth] ? (~dx + 1'b1) : dx;
      ys_mag = ys[CoordWidth] ? (~ys + 1'b1) : ys;

      // |dx| fits 32 bits; the product of magnitudes stays below 2^64
      product      = ys_mag * {1'b0, dx_mag[CoordWidth-1:0]};
      half_product = product[EnergyWidth-1:1];

      step.start     = start_eff;
      step.x         = x_value;
      step.y         = y_value;
      step.path_step = {dx_mag[CoordWidth-1:0], 16'h0000};
      step.term      = (dx[CoordWidth] != ys[CoordWidth])
                       ? -$signed({1'b0, half_product})
                       : $signed({1'b0, half_product});
   end

   // Advance the curve history whenever an item leaves the input stage.
   always_comb begin
      prev_raw_x_in  = prev_raw_x_ff;
      last_kept_x_in = last_kept_x_ff;
      last_kept_y_in = last_kept_y_ff;
      have_point_in  = have_point_ff;
      if (advance) begin
         prev_raw_x_in = x_value;
         have_point_in = 1'b1;
         if (keep) begin
            last_kept_x_in = x_value;
            last_kept_y_in = y_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_x_ff  <= '0;
         last_kept_x_ff <= '0;
         last_kept_y_ff <= '0;
         have_point_ff  <= 1'b0;
      end else begin
         prev_raw_x_ff  <= prev_raw_x_in;
         last_kept_x_ff <= last_kept_x_in;
         last_kept_y_ff <= last_kept_y_in;
         have_point_ff  <= have_point_in;
      end
   end

endmodule

/* sv/dti_accum.sv */
// ---------------------------------------------------------------------------
// dti_accum
// Saturating path and energy accumulators; they double as the result
// register of the block.
// ---------------------------------------------------------------------------
module dti_accum (
   input  logic                                    clock,
   input  logic                                    load,
   input  dti_pkg::dti_step_type                   step,
   output logic signed [dti_pkg::CoordWidth-1:0]   kept_x,
   output logic signed [dti_pkg::CoordWidth-1:0]   kept_y,
   output logic        [dti_pkg::PathWidth-1:0]    path_length,
   output logic signed [dti_pkg::EnergyWidth-1:0]  energy_sum,
   output logic                                    saturated
);
   import dti_pkg::*;

   localparam logic [PathWidth-1:0]   PathMax   = {PathWidth{1'b1}};
   localparam logic [EnergyWidth-1:0] EnergyMax = {1'b0, {(EnergyWidth-1){1'b1}}};
   localparam logic [EnergyWidth-1:0] EnergyMin = {1'b1, {(EnergyWidth-1){1'b0}}};

   logic signed [CoordWidth-1:0]  x_ff, x_in;
   logic signed [CoordWidth-1:0]  y_ff, y_in;
   logic        [PathWidth-1:0]   path_acc_ff, path_acc_in;
   logic signed [EnergyWidth-1:0] energy_acc_ff, energy_acc_in;
   logic                          sat_ff, sat_in;

   logic [PathWidth:0]   path_sum;
   logic [EnergyWidth:0] energy_sum_wide;
   logic                 path_over;
   logic                 energy_over;

   always_comb begin
      path_sum        = {1'b0, path_acc_ff} + {{(PathWidth+1-PathStepWidth){1'b0}}, step.path_step};
      energy_sum_wide = {energy_acc_ff[EnergyWidth-1], energy_acc_ff}
                        + {step.term[EnergyWidth-1], step.term};
      path_over   = path_sum[PathWidth];
      energy_over = energy_sum_wide[EnergyWidth] != energy_sum_wide[EnergyWidth-1];

      x_in          = x_ff;
      y_in          = y_ff;
      path_acc_in   = path_acc_ff;
      energy_acc_in = energy_acc_ff;
      sat_in        = sat_ff;
      if (load) begin
         x_in = step.x;
         y_in = step.y;
         if (step.start) begin
            path_acc_in   = '0;
            energy_acc_in = '0;
            sat_in        = 1'b0;
         end else begin
            path_acc_in   = path_over ? PathMax : path_sum[PathWidth-1:0];
            if (energy_over) begin
               energy_acc_in = energy_sum_wide[EnergyWidth] ? EnergyMin : EnergyMax;
            end else begin
               energy_acc_in = energy_sum_wide[EnergyWidth-1:0];
            end
            sat_in = sat_ff || path_over || energy_over;
         end
      end
   end

   // Payload only: a curve start always precedes the first use of the sums.
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      path_acc_ff   <= path_acc_in;
      energy_acc_ff <= energy_acc_in;
      sat_ff        <= sat_in;
   end

   assign kept_x      = x_ff;
   assign kept_y      = y_ff;
   assign path_length = path_acc_ff;
   assign energy_sum  = energy_acc_ff;
   assign saturated   = sat_ff;

endmodule

/* sv/dedup_trapezoid_integrator.sv */
// ---------------------------------------------------------------------------
// dedup_trapezoid_integrator
// Point deduplication and trapezoidal integration of a sampled curve.
// ---------------------------------------------------------------------------
// Accepts one (x, y) point per clock when not stalled and returns one result
// transaction per kept point via the input, increment and result registers.
// The first point of a curve (tuser high, or the first point after reset) is
// always kept with zero sums; a later point is kept when |x - previous input
// x| >= min_step and dropped otherwise, producing no result. Throughput is
// one point per cycle when not stalled: the input register feeds the keep
// decision and the 33x32 increment multiply, and the accumulator stage closes
// its add-and-clamp loop on the path and energy sums. path_length and
// energy_sum saturate, and rsp_tuser stays high until the next curve start.
// Write min_step (unsigned Q15.16, reset 0) only while no point is in flight.
// ---------------------------------------------------------------------------
`include "dedup_trapezoid_integrator_macros.svh"

module dedup_trapezoid_integrator (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_we,
   input  logic [30:0]  csr_wdata,      // min_step
   // input points
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,      // [31:0] x_value, [63:32] y_value
   input  logic         req_tuser,      // [0] curve_start
   // results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,      // [31:0] kept_x, [63:32] kept_y,
                                        // [126:64] path_length,
                                        // [190:127] energy_sum, [191] zero
   output logic         rsp_tuser       // [0] saturated
);
   import dti_pkg::*;

   // configuration register
   logic [StepWidth-1:0] min_step_ff;

   // input stage
   logic                         s0_valid_ff, s0_valid_in;
   logic signed [CoordWidth-1:0] s0_x_ff;
   logic signed [CoordWidth-1:0] s0_y_ff;
   logic                         s0_start_ff;

   // increment stage
   logic         s1_valid_ff, s1_valid_in;
   dti_step_type s1_step_ff;

   // result stage
   logic rsp_valid_ff, rsp_valid_in;

   logic         s0_ready, s1_ready, s2_ready;
   logic         s0_advance;
   logic         acc_load;
   logic         keep;
   dti_step_type step;

   logic signed [CoordWidth-1:0]  kept_x;
   logic signed [CoordWidth-1:0]  kept_y;
   logic        [PathWidth-1:0]   path_length;
   logic signed [EnergyWidth-1:0] energy_sum;
   logic                          saturated;

   // A stage takes new data when it is empty or its content moves on.
   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign s0_ready   = !s0_valid_ff || s1_ready;
   assign s0_advance = s0_valid_ff && s1_ready;
   assign acc_load   = s1_valid_ff && s2_ready;
   assign req_tready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_step_ff <= '0;
      end else if (csr_we) begin
         min_step_ff <= csr_wdata;
      end
   end

   // Valid bits: dropped points vanish between the input and increment stages.
   always_comb begin
      s0_valid_in  = s0_valid_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s0_ready) begin
         s0_valid_in = req_tvalid;
      end
      if (s1_ready) begin
         s1_valid_in = s0_valid_ff && keep;
      end
      if (s2_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the accepted transaction; hold it while downstream is full.
   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_x_ff     <= req_tdata[CoordWidth-1:0];
         s0_y_ff     <= req_tdata[2*CoordWidth-1:CoordWidth];
         s0_start_ff <= req_tuser;
      end
      if (s1_ready) begin
         s1_step_ff <= step;
      end
   end

   dti_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .advance     (s0_advance),
      .x_value     (s0_x_ff),
      .y_value     (s0_y_ff),
      .curve_start (s0_start_ff),
      .min_step    (min_step_ff),
      .keep        (keep),
      .step        (step)
   );

   dti_accum u_accum (
      .clock       (clock),
      .load        (acc_load),
      .step        (s1_step_ff),
      .kept_x      (kept_x),
      .kept_y      (kept_y),
      .path_length (path_length),
      .energy_sum  (energy_sum),
      .saturated   (saturated)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, energy_sum, path_length, kept_y, kept_x};
   assign rsp_tuser  = saturated;

   // A curve start lands in the result with cleared sums and flag.
   `DTI_ASSERT_NEXT(a_start_clears, clock, reset, acc_load && s1_step_ff.start, path_length == '0 && energy_sum == '0 && !saturated, "curve start did not clear the sums")
   // Within a curve the path length never shrinks.
   `DTI_ASSERT_NEXT(a_path_monotonic, clock, reset, acc_load && !s1_step_ff.start, path_length >= $past(path_length), "path length decreased within a curve")
   // The saturation flag is sticky until the next curve start.
   `DTI_ASSERT_NEXT(a_sat_sticky, clock, reset, acc_load && !s1_step_ff.start && saturated, saturated, "saturation flag dropped within a curve")
   // A dropped point never reaches the increment stage.
   `DTI_ASSERT_NEXT(a_drop_no_result, clock, reset, s0_advance && !keep, !s1_valid_ff, "dropped point entered the increment stage")

endmodule
